### rtl/vccp_pkg.sv
// vccp_pkg: types and constants shared by the view cone cube priority block.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package vccp_pkg;

    // multiply-accumulate unit geometry
    localparam int ACC_W = 114;
    localparam int MA_W  = 72;
    localparam int MB_W  = 64;
    localparam int DIG_W = 16;

    // request type codes on the input
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // status codes on the result
    localparam logic [1:0] ST_SEND    = 2'd0;
    localparam logic [1:0] ST_NOSEND  = 2'd1;
    localparam logic [1:0] ST_NOVIEWS = 2'd2;

    localparam logic [39:0] PRIO_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [39:0] PRIO_ONE = 40'd65536;
    localparam logic [43:0] EPS_Q16  = 44'd66;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_CLEAR,
        OP_QUERY
    } op_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [1:0]         view_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [16:0]        cos_half;
        logic [16:0]        sin_half;
        logic [31:0]        extent;
    } req_t;

    typedef struct packed {
        logic [39:0] priority_res;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        op_t  op;
        req_t item;
    } cmd_t;

    typedef struct packed {
        logic                    start;
        logic                    neg;
        logic [1:0]              ndig;   // digits of b minus one
        logic [MA_W-1:0]         a;
        logic [MB_W-1:0]         b;
        logic signed [ACC_W-1:0] init;
    } mac_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] acc;
    } mac_rsp_t;

    typedef struct packed {
        logic        start;
        logic [71:0] d2;
        logic [31:0] ext;
    } rd_req_t;

    typedef struct packed {
        logic        done;
        logic [54:0] quot;
    } rd_rsp_t;

endpackage

### rtl/view_cone_cube_priority.sv
// view_cone_cube_priority: top level, front end with command queue and the
// back-end sequencer. Depends on vccp_pkg, vccp_front and vccp_back.
//
//  channel   ports                    handshake
//  --------  -----------------------  ----------------------------------------
//  request   req (req_t)              taken when start is high and busy is low
//  result    result (res_t)           valid for the single cycle done is high
//
// Loads and clears are handled in the back end's idle state. A query takes
// every slot in turn: an empty slot is skipped, and a view whose central sphere
// holds the cube ends there. A view ends after its side test when the cube is
// behind it and after the angle test when that fails. When both pass, most of
// its time goes to the bit-per-cycle square root and divide.
// The result strobe is registered in S_FIN after the last view's step. The two-entry
// queue keeps taking transactions while a query runs; busy rises only when
// it is full.
// Reset clears the queue, all view valid bits and the sequencer.
// The receiver cannot stall: done is a one-cycle strobe.
module view_cone_cube_priority #(
    parameter int MAX_VIEWS = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  vccp_pkg::req_t req,
    output logic           done,
    output vccp_pkg::res_t result
);

    logic           cmd_valid;
    logic           cmd_pop;
    vccp_pkg::cmd_t cmd;

    // front: decode, drop loads to missing slots and unknown requests, queue
    vccp_front #(
        .MAX_VIEWS (MAX_VIEWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // back: view table plus the per-view distance, cone and priority steps
    vccp_back #(
        .MAX_VIEWS (MAX_VIEWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .done      (done),
        .result    (result)
    );

endmodule

### rtl/vccp_front.sv
// vccp_front: takes transactions, decodes the request type, drops no-ops,
// and queues the rest for the back end. Depends on vccp_pkg.
module vccp_front #(
    parameter int MAX_VIEWS = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  vccp_pkg::req_t  req,
    output logic            cmd_valid,
    input  logic            cmd_pop,
    output vccp_pkg::cmd_t  cmd
);

    vccp_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    vccp_pkg::cmd_t cls;
    logic           keep;
    logic           push;

    always_comb
    begin
        cls.item = req;
        cls.op   = vccp_pkg::OP_QUERY;
        keep     = 1'b0;
        unique case (req.req_type)
            vccp_pkg::REQ_LOAD:
            begin
                cls.op = vccp_pkg::OP_LOAD;
                keep   = int'(req.view_index) < MAX_VIEWS;
            end
            vccp_pkg::REQ_CLEAR:
            begin
                cls.op = vccp_pkg::OP_CLEAR;
                keep   = 1'b1;
            end
            vccp_pkg::REQ_QUERY:
            begin
                cls.op = vccp_pkg::OP_QUERY;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;   // unknown request: nothing to do
            end
        endcase
    end

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start & ~busy & keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign cnt_next  = cnt_reg + 2'(push) - 2'(cmd_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (cmd_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

### rtl/vccp_mac.sv
// vccp_mac: shared multiply-accumulate, acc = init +/- a*b, taking b in
// 16-bit digits, one digit per cycle. Depends on vccp_pkg.
module vccp_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  vccp_pkg::mac_req_t mreq,
    output vccp_pkg::mac_rsp_t mrsp
);

    logic [vccp_pkg::MA_W-1:0]         a_reg;
    logic [vccp_pkg::MB_W-1:0]         b_reg;
    logic [1:0]                        dig_reg;
    logic [1:0]                        last_reg;
    logic                              neg_reg;
    logic                              run_reg;
    logic                              done_reg;
    logic signed [vccp_pkg::ACC_W-1:0] acc_reg;
    logic [vccp_pkg::MA_W+vccp_pkg::DIG_W-1:0] pp;
    logic [vccp_pkg::ACC_W-1:0]        pp_ext;
    logic [vccp_pkg::ACC_W-1:0]        term;
    logic signed [vccp_pkg::ACC_W-1:0] acc_next;

    always_comb
    begin
        pp     = a_reg * b_reg[vccp_pkg::DIG_W-1:0];
        pp_ext = vccp_pkg::ACC_W'(pp);
        unique case (dig_reg)
            2'd0:    term = pp_ext;
            2'd1:    term = pp_ext << vccp_pkg::DIG_W;
            2'd2:    term = pp_ext << (2 * vccp_pkg::DIG_W);
            default: term = pp_ext << (3 * vccp_pkg::DIG_W);
        endcase
        acc_next = neg_reg ? (acc_reg - $signed(term)) : (acc_reg + $signed(term));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (mreq.start)
                run_reg <= 1'b1;
            else if (run_reg && dig_reg == last_reg)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mreq.start)
        begin
            a_reg    <= mreq.a;
            b_reg    <= mreq.b;
            neg_reg  <= mreq.neg;
            last_reg <= mreq.ndig;
            dig_reg  <= 2'd0;
            acc_reg  <= mreq.init;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg >> vccp_pkg::DIG_W;
            dig_reg <= dig_reg + 2'd1;
        end
    end

    assign mrsp.done = done_reg;
    assign mrsp.acc  = acc_reg;

endmodule

### rtl/vccp_rootdiv.sv
// vccp_rootdiv: floor square root of d2*2^14, one root bit per cycle, then
// floor(ext*2^23 / (root + 66)), one quotient bit per cycle. Depends on vccp_pkg.
module vccp_rootdiv (
    input  logic              clk,
    input  logic              rst_n,
    input  vccp_pkg::rd_req_t rreq,
    output vccp_pkg::rd_rsp_t rrsp
);

    typedef enum logic [1:0] {
        R_IDLE,
        R_ROOT,
        R_DIV
    } rstate_t;

    rstate_t     state_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [85:0] rad_reg;
    logic [44:0] rem_reg;
    logic [42:0] root_reg;
    logic [54:0] num_reg;
    logic [43:0] den_reg;
    logic [43:0] drem_reg;
    logic [54:0] quot_reg;

    logic [46:0] rem2;
    logic [46:0] trial;
    logic        r_ge;
    logic [46:0] rem_sub;
    logic [42:0] root_next;
    logic [44:0] drem2;
    logic        d_ge;
    logic [44:0] drem_sub;

    always_comb
    begin
        rem2      = {rem_reg, rad_reg[85:84]};
        trial     = {2'b00, root_reg, 2'b01};
        r_ge      = rem2 >= trial;
        rem_sub   = r_ge ? (rem2 - trial) : rem2;
        root_next = {root_reg[41:0], r_ge};
        drem2     = {drem_reg, num_reg[54]};
        d_ge      = drem2 >= {1'b0, den_reg};
        drem_sub  = d_ge ? (drem2 - {1'b0, den_reg}) : drem2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                R_IDLE:
                begin
                    if (rreq.start)
                    begin
                        state_reg <= R_ROOT;
                        cnt_reg   <= 6'd42;
                    end
                end
                R_ROOT:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= R_DIV;
                        cnt_reg   <= 6'd54;
                    end
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                R_DIV:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= R_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == R_IDLE && rreq.start)
        begin
            rad_reg  <= {rreq.d2, 14'd0};
            rem_reg  <= '0;
            root_reg <= '0;
            num_reg  <= {rreq.ext, 23'd0};
        end
        else if (state_reg == R_ROOT)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_sub[44:0];
            root_reg <= root_next;
            if (cnt_reg == 6'd0)
            begin
                den_reg  <= {1'b0, root_next} + vccp_pkg::EPS_Q16;
                drem_reg <= '0;
            end
        end
        else if (state_reg == R_DIV)
        begin
            num_reg  <= num_reg << 1;
            drem_reg <= drem_sub[43:0];
            quot_reg <= {quot_reg[53:0], d_ge};
        end
    end

    assign rrsp.done = done_reg;
    assign rrsp.quot = quot_reg;

endmodule

### rtl/vccp_back.sv
// vccp_back: view table and the per-view sequencer that runs each query on
// the shared multiply-accumulate and root/divide units. Depends on vccp_pkg,
// vccp_mac and vccp_rootdiv.
module vccp_back #(
    parameter int MAX_VIEWS = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  vccp_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           done,
    output vccp_pkg::res_t result
);

    localparam int VW = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SEL,
        S_PVEC,
        S_D2A,
        S_D2B,
        S_D2C,
        S_BR,
        S_DOTA,
        S_DOTB,
        S_DOTC,
        S_SIN,
        S_COS,
        S_E,
        S_L2,
        S_EC,
        S_ROOT,
        S_UPD,
        S_NEXT,
        S_FIN
    } state_t;

    // view table
    logic signed [31:0] tpx [MAX_VIEWS];
    logic signed [31:0] tpy [MAX_VIEWS];
    logic signed [31:0] tpz [MAX_VIEWS];
    logic signed [15:0] tdx [MAX_VIEWS];
    logic signed [15:0] tdy [MAX_VIEWS];
    logic signed [15:0] tdz [MAX_VIEWS];
    logic [16:0]        tcos [MAX_VIEWS];
    logic [16:0]        tsin [MAX_VIEWS];
    logic [31:0]        trad [MAX_VIEWS];
    logic [MAX_VIEWS-1:0] valid_reg;

    // control
    state_t          state_reg;
    logic [VW-1:0]   vcnt_reg;
    logic            issued_reg;
    logic            any_reg;
    logic            send_reg;
    logic            done_reg;
    vccp_pkg::res_t  result_reg;

    // working payload
    logic signed [31:0] qx_reg, qy_reg, qz_reg;
    logic [31:0]        ext_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic signed [15:0] dx_reg, dy_reg, dz_reg;
    logic [16:0]        cos_reg, sin_reg;
    logic [31:0]        rad_reg;
    logic [34:0]        pmag_reg [3];
    logic [2:0]         pneg_reg;
    logic [15:0]        dmag_reg [3];
    logic [2:0]         dneg_reg;
    logic [33:0]        bigr_reg;
    logic [71:0]        d2_reg;
    logic [55:0]        lhs_reg;
    logic [33:0]        cos2_reg;
    logic [71:0]        e_reg;
    logic [39:0]        prio_reg;
    logic [39:0]        best_reg;

    vccp_pkg::mac_req_t mreq;
    vccp_pkg::mac_rsp_t mrsp;
    vccp_pkg::rd_req_t  rreq;
    vccp_pkg::rd_rsp_t  rrsp;

    logic acc_neg;
    logic acc_zero;
    logic is_last;
    logic [39:0] quot_sat;

    function automatic logic signed [34:0] pdiff(logic signed [31:0] q,
                                                 logic signed [31:0] v,
                                                 logic [31:0] e);
        logic signed [34:0] t;
        t = {{2{q[31]}}, q, 1'b0} - {{2{v[31]}}, v, 1'b0} + {3'b000, e};
        return t;
    endfunction

    function automatic logic [34:0] mag35(logic signed [34:0] v);
        logic [34:0] m;
        m = v[34] ? (35'd0 - v) : v;
        return m;
    endfunction

    function automatic logic [15:0] mag16(logic signed [15:0] v);
        logic [15:0] m;
        m = v[15] ? (16'd0 - v) : v;
        return m;
    endfunction

    vccp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .mreq  (mreq),
        .mrsp  (mrsp)
    );

    vccp_rootdiv u_rootdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .rreq  (rreq),
        .rrsp  (rrsp)
    );

    assign acc_neg  = mrsp.acc[vccp_pkg::ACC_W-1];
    assign acc_zero = (mrsp.acc == '0);
    assign is_last  = (vcnt_reg == VW'(MAX_VIEWS - 1));
    assign quot_sat = (|rrsp.quot[54:40]) ? vccp_pkg::PRIO_MAX : rrsp.quot[39:0];
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;

    // operand select for the shared units
    always_comb
    begin
        mreq      = '0;
        mreq.init = mrsp.acc;
        unique case (state_reg)
            S_D2A:
            begin
                mreq.start = ~issued_reg;
                mreq.init  = '0;
                mreq.a     = 72'(pmag_reg[0]);
                mreq.b     = 64'(pmag_reg[0]);
                mreq.ndig  = 2'd2;
            end
            S_D2B:
            begin
                mreq.start = ~issued_reg;
                mreq.a     = 72'(pmag_reg[1]);
                mreq.b     = 64'(pmag_reg[1]);
                mreq.ndig  = 2'd2;
            end
            S_D2C:
            begin
                mreq.start = ~issued_reg;
                mreq.a     = 72'(pmag_reg[2]);
                mreq.b     = 64'(pmag_reg[2]);
                mreq.ndig  = 2'd2;
            end
            S_BR:
            begin
                mreq.start = ~issued_reg;
                mreq.neg   = 1'b1;
                mreq.a     = 72'(bigr_reg);
                mreq.b     = 64'(bigr_reg);
                mreq.ndig  = 2'd2;
            end
            S_DOTA:
            begin
                mreq.start = ~issued_reg;
                mreq.init  = '0;
                mreq.neg   = pneg_reg[0] ^ dneg_reg[0];
                mreq.a     = 72'({pmag_reg[0], 2'b00});
                mreq.b     = 64'(dmag_reg[0]);
            end
            S_DOTB:
            begin
                mreq.start = ~issued_reg;
                mreq.neg   = pneg_reg[1] ^ dneg_reg[1];
                mreq.a     = 72'({pmag_reg[1], 2'b00});
                mreq.b     = 64'(dmag_reg[1]);
            end
            S_DOTC:
            begin
                mreq.start = ~issued_reg;
                mreq.neg   = pneg_reg[2] ^ dneg_reg[2];
                mreq.a     = 72'({pmag_reg[2], 2'b00});
                mreq.b     = 64'(dmag_reg[2]);
            end
            S_SIN:
            begin
                mreq.start = ~issued_reg;
                mreq.a     = 72'(ext_reg);
                mreq.b     = 64'(sin_reg);
                mreq.ndig  = 2'd1;
            end
            S_COS:
            begin
                mreq.start = ~issued_reg;
                mreq.init  = '0;
                mreq.a     = 72'(cos_reg);
                mreq.b     = 64'(cos_reg);
                mreq.ndig  = 2'd1;
            end
            S_E:
            begin
                mreq.start = ~issued_reg;
                mreq.init  = vccp_pkg::ACC_W'(d2_reg);
                mreq.neg   = 1'b1;
                mreq.a     = 72'(ext_reg);
                mreq.b     = 64'(ext_reg);
                mreq.ndig  = 2'd1;
            end
            S_L2:
            begin
                mreq.start = ~issued_reg;
                mreq.init  = '0;
                mreq.a     = 72'(lhs_reg);
                mreq.b     = 64'(lhs_reg);
                mreq.ndig  = 2'd3;
            end
            S_EC:
            begin
                mreq.start = ~issued_reg;
                mreq.neg   = 1'b1;
                mreq.a     = e_reg;
                mreq.b     = 64'(cos2_reg);
                mreq.ndig  = 2'd2;
            end
            default:
            begin
                mreq.start = 1'b0;
            end
        endcase

        rreq.start = (state_reg == S_ROOT) && !issued_reg;
        rreq.d2    = d2_reg;
        rreq.ext   = ext_reg;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vcnt_reg   <= '0;
            issued_reg <= 1'b0;
            any_reg    <= 1'b0;
            send_reg   <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
            valid_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (mreq.start || rreq.start)
                issued_reg <= 1'b1;
            else if (mrsp.done || rrsp.done)
                issued_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        unique case (cmd.op)
                            vccp_pkg::OP_LOAD:
                            begin
                                for (int i = 0; i < MAX_VIEWS; i++)
                                begin
                                    if (int'(cmd.item.view_index) == i)
                                        valid_reg[i] <= 1'b1;
                                end
                            end
                            vccp_pkg::OP_CLEAR:
                            begin
                                valid_reg <= '0;
                            end
                            vccp_pkg::OP_QUERY:
                            begin
                                any_reg   <= 1'b0;
                                send_reg  <= 1'b0;
                                vcnt_reg  <= '0;
                                state_reg <= S_SEL;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SEL:
                begin
                    if (valid_reg[vcnt_reg])
                    begin
                        any_reg   <= 1'b1;
                        state_reg <= S_PVEC;
                    end
                    else
                        state_reg <= S_NEXT;
                end
                S_PVEC: state_reg <= S_D2A;
                S_D2A:  if (mrsp.done) state_reg <= S_D2B;
                S_D2B:  if (mrsp.done) state_reg <= S_D2C;
                S_D2C:  if (mrsp.done) state_reg <= S_BR;
                S_BR:
                begin
                    // inside the central sphere: priority is the half side
                    if (mrsp.done)
                        state_reg <= acc_neg ? S_UPD : S_DOTA;
                end
                S_DOTA: if (mrsp.done) state_reg <= S_DOTB;
                S_DOTB: if (mrsp.done) state_reg <= S_DOTC;
                S_DOTC: if (mrsp.done) state_reg <= S_SIN;
                S_SIN:
                begin
                    if (mrsp.done)
                        state_reg <= (acc_neg || acc_zero) ? S_NEXT : S_COS;
                end
                S_COS:  if (mrsp.done) state_reg <= S_E;
                S_E:    if (mrsp.done) state_reg <= S_L2;
                S_L2:   if (mrsp.done) state_reg <= S_EC;
                S_EC:
                begin
                    if (mrsp.done)
                        state_reg <= (!acc_neg && !acc_zero) ? S_ROOT : S_NEXT;
                end
                S_ROOT: if (rrsp.done) state_reg <= S_UPD;
                S_UPD:
                begin
                    send_reg  <= 1'b1;
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (is_last)
                        state_reg <= S_FIN;
                    else
                    begin
                        vcnt_reg  <= vcnt_reg + VW'(1);
                        state_reg <= S_SEL;
                    end
                end
                S_FIN:
                begin
                    done_reg <= 1'b1;
                    if (!any_reg)
                    begin
                        result_reg.priority_res <= vccp_pkg::PRIO_ONE;
                        result_reg.status       <= vccp_pkg::ST_NOVIEWS;
                    end
                    else if (send_reg)
                    begin
                        result_reg.priority_res <= best_reg;
                        result_reg.status       <= vccp_pkg::ST_SEND;
                    end
                    else
                    begin
                        result_reg.priority_res <= '0;
                        result_reg.status       <= vccp_pkg::ST_NOSEND;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // table writes and working payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            if (cmd.op == vccp_pkg::OP_LOAD)
            begin
                for (int i = 0; i < MAX_VIEWS; i++)
                begin
                    if (int'(cmd.item.view_index) == i)
                    begin
                        tpx[i]  <= cmd.item.pos_x;
                        tpy[i]  <= cmd.item.pos_y;
                        tpz[i]  <= cmd.item.pos_z;
                        tdx[i]  <= cmd.item.dir_x;
                        tdy[i]  <= cmd.item.dir_y;
                        tdz[i]  <= cmd.item.dir_z;
                        tcos[i] <= cmd.item.cos_half;
                        tsin[i] <= cmd.item.sin_half;
                        trad[i] <= cmd.item.extent;
                    end
                end
            end
            qx_reg  <= cmd.item.pos_x;
            qy_reg  <= cmd.item.pos_y;
            qz_reg  <= cmd.item.pos_z;
            ext_reg <= cmd.item.extent;
        end

        if (state_reg == S_SEL)
        begin
            vx_reg  <= tpx[vcnt_reg];
            vy_reg  <= tpy[vcnt_reg];
            vz_reg  <= tpz[vcnt_reg];
            dx_reg  <= tdx[vcnt_reg];
            dy_reg  <= tdy[vcnt_reg];
            dz_reg  <= tdz[vcnt_reg];
            cos_reg <= tcos[vcnt_reg];
            sin_reg <= tsin[vcnt_reg];
            rad_reg <= trad[vcnt_reg];
        end

        if (state_reg == S_PVEC)
        begin
            pmag_reg[0] <= mag35(pdiff(qx_reg, vx_reg, ext_reg));
            pmag_reg[1] <= mag35(pdiff(qy_reg, vy_reg, ext_reg));
            pmag_reg[2] <= mag35(pdiff(qz_reg, vz_reg, ext_reg));
            pneg_reg    <= {pdiff(qz_reg, vz_reg, ext_reg) < 0,
                            pdiff(qy_reg, vy_reg, ext_reg) < 0,
                            pdiff(qx_reg, vx_reg, ext_reg) < 0};
            dmag_reg[0] <= mag16(dx_reg);
            dmag_reg[1] <= mag16(dy_reg);
            dmag_reg[2] <= mag16(dz_reg);
            dneg_reg    <= {dz_reg[15], dy_reg[15], dx_reg[15]};
            bigr_reg    <= {1'b0, rad_reg, 1'b0} + {2'b00, ext_reg};
        end

        if (state_reg == S_D2C && mrsp.done)
            d2_reg <= mrsp.acc[71:0];
        if (state_reg == S_BR && mrsp.done)
            prio_reg <= {1'b0, ext_reg, 7'd0};
        if (state_reg == S_SIN && mrsp.done)
            lhs_reg <= mrsp.acc[55:0];
        if (state_reg == S_COS && mrsp.done)
            cos2_reg <= mrsp.acc[33:0];
        if (state_reg == S_E && mrsp.done)
            e_reg <= mrsp.acc[71:0];
        if (state_reg == S_ROOT && rrsp.done)
            prio_reg <= quot_sat;
        if (state_reg == S_UPD && (!send_reg || prio_reg > best_reg))
            best_reg <= prio_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### tb/testbench.sv
// testbench: self-checking bench for view_cone_cube_priority.
// Depends on vccp_pkg and the RTL top; predicts each query result and compares it.
`timescale 1ns / 1ps

module testbench;

    // request code the block ignores
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 800;   // four views passing the cone test, plus margin
    localparam int REQ_W = $bits(vccp_pkg::req_t);

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    vccp_pkg::req_t req;
    logic done;
    vccp_pkg::res_t result;

    view_cone_cube_priority #(.MAX_VIEWS(4)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    // predictor copy of the view table
    longint      view_pos [4][3];
    longint      view_dir [4][3];
    logic [63:0] view_cos [4];
    logic [63:0] view_sin [4];
    logic [63:0] view_rad [4];
    logic        view_ok  [4];

    vccp_pkg::res_t prio_expected[$];
    int   mismatches;
    int   burst_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit: far beyond the slowest legal run
    initial
    begin
        #20ms;
        $display("view_cone_cube_priority: mismatch");
        $finish;
    end

    task automatic report(input string what);
        begin
            $display("ERROR @%0t: %s", $realtime, what);
            mismatches++;
        end
    endtask

    // floor square root, 44 result bits
    function automatic logic [63:0] isqrt(input logic [127:0] n);
        logic [63:0] root;
        logic [63:0] t;
        begin
            root = 64'd0;
            for (int k = 43; k >= 0; k--)
            begin
                t = root | (64'd1 << k);
                if (!(n < {64'd0, t} * {64'd0, t}))
                    root = t;
            end
            return root;
        end
    endfunction

    // best priority of a cube over all valid views
    function automatic vccp_pkg::res_t cull_priority(input vccp_pkg::req_t q);
        vccp_pkg::res_t r;
        logic        any;
        logic        send;
        logic [63:0] best;
        logic [63:0] ext;
        logic [63:0] mag;
        logic [63:0] big_r;
        logic [63:0] prio;
        logic [63:0] dq;
        logic [127:0] d2;
        logic [127:0] e;
        longint      p [3];
        longint      qpos [3];
        longint      dot;
        longint      lhs;
        begin
            any  = 1'b0;
            send = 1'b0;
            best = 64'd0;
            ext  = {32'd0, q.extent};
            qpos[0] = q.pos_x;
            qpos[1] = q.pos_y;
            qpos[2] = q.pos_z;
            for (int i = 0; i < 4; i++)
            begin
                if (!view_ok[i])
                    continue;
                any = 1'b1;
                d2  = 128'd0;
                dot = 0;
                // vector to the cube centre, units of 2^-9
                for (int k = 0; k < 3; k++)
                begin
                    p[k] = 2 * qpos[k] + longint'(ext) - 2 * view_pos[i][k];
                    mag  = (p[k] < 0) ? -p[k] : p[k];
                    d2   = d2 + {64'd0, mag} * {64'd0, mag};
                    dot  = dot + p[k] * view_dir[i][k];
                end
                big_r = 2 * view_rad[i] + ext;
                if (d2 < {64'd0, big_r} * {64'd0, big_r})
                    prio = ext << 7;   // cube inside the central sphere
                else
                begin
                    lhs = 4 * dot + longint'(ext * view_sin[i]);
                    e   = d2 - {64'd0, ext} * {64'd0, ext};   // wraps like the 128-bit math
                    if (lhs <= 0 ||
                        !((e * {64'd0, view_cos[i] * view_cos[i]}) <
                          ({64'd0, lhs} * {64'd0, lhs})))
                        continue;
                    dq   = isqrt(d2 << 14);
                    prio = (ext << 23) / (dq + 64'd66);
                end
                if (prio > {24'd0, vccp_pkg::PRIO_MAX})
                    prio = {24'd0, vccp_pkg::PRIO_MAX};
                if (!send || prio > best)
                    best = prio;
                send = 1'b1;
            end
            if (!any)
            begin
                r.priority_res = vccp_pkg::PRIO_ONE;
                r.status       = vccp_pkg::ST_NOVIEWS;
            end
            else if (send)
            begin
                r.priority_res = best[39:0];
                r.status       = vccp_pkg::ST_SEND;
            end
            else
            begin
                r.priority_res = 40'd0;
                r.status       = vccp_pkg::ST_NOSEND;
            end
            return r;
        end
    endfunction

    // apply one accepted transaction to the predictor
    task automatic predict(input vccp_pkg::req_t q);
        begin
            case (q.req_type)
                vccp_pkg::REQ_LOAD:
                begin
                    view_pos[q.view_index][0] = q.pos_x;
                    view_pos[q.view_index][1] = q.pos_y;
                    view_pos[q.view_index][2] = q.pos_z;
                    view_dir[q.view_index][0] = q.dir_x;
                    view_dir[q.view_index][1] = q.dir_y;
                    view_dir[q.view_index][2] = q.dir_z;
                    view_cos[q.view_index]    = {47'd0, q.cos_half};
                    view_sin[q.view_index]    = {47'd0, q.sin_half};
                    view_rad[q.view_index]    = {32'd0, q.extent};
                    view_ok[q.view_index]     = 1'b1;
                end
                vccp_pkg::REQ_CLEAR:
                    for (int i = 0; i < 4; i++)
                        view_ok[i] = 1'b0;
                vccp_pkg::REQ_QUERY:
                    prio_expected.push_back(cull_priority(q));
                default:
                    ;
            endcase
        end
    endtask

    // drive one transaction; start stays high so back-to-back items keep flowing
    task automatic send_item(input vccp_pkg::req_t q);
        begin
            @(negedge clk);
            start <= 1'b1;
            req   <= q;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            predict(q);
        end
    endtask

    task automatic idle(input int cycles);
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    // sender bursts: random length, random gaps, some long gapless stretches
    task automatic pace;
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle($urandom_range(1, 20));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
            end
            burst_left--;
        end
    endtask

    function automatic vccp_pkg::req_t mk(input logic [1:0] t, input int idx,
                                input int x, input int y, input int z,
                                input int dx, input int dy, input int dz,
                                input int c, input int s, input logic [31:0] ext);
        vccp_pkg::req_t q;
        begin
            q.req_type   = t;
            q.view_index = idx[1:0];
            q.pos_x      = x;
            q.pos_y      = y;
            q.pos_z      = z;
            q.dir_x      = dx[15:0];
            q.dir_y      = dy[15:0];
            q.dir_z      = dz[15:0];
            q.cos_half   = c[16:0];
            q.sin_half   = s[16:0];
            q.extent     = ext;
            return q;
        end
    endfunction

    // result checker: every strobe must match the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (prio_expected.size() == 0)
                report("result with no query outstanding");
            else
            begin
                vccp_pkg::res_t want;
                want = prio_expected.pop_front();
                if (result.priority_res !== want.priority_res)
                    report($sformatf("priority_res got %0d want %0d",
                                     result.priority_res, want.priority_res));
                if (result.status !== want.status)
                    report($sformatf("status got %0d want %0d", result.status, want.status));
            end
        end
    end

    task automatic test_no_views;
        begin
            send_item(mk(vccp_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            send_item(mk(vccp_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 256));
        end
    endtask

    task automatic test_cone_cases;
        begin
            // view at origin looking +x, 45 degree half angle, radius 2.0
            send_item(mk(vccp_pkg::REQ_LOAD, 0, 0, 0, 0, 16384, 0, 0, 46341, 46341, 512));
            // central sphere
            send_item(mk(vccp_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 256));
            // inside cone
            send_item(mk(vccp_pkg::REQ_QUERY, 0, 10240, 0, 0, 0, 0, 0, 0, 0, 256));
            // behind: no send
            send_item(mk(vccp_pkg::REQ_QUERY, 0, -10240, 0, 0, 0, 0, 0, 0, 0, 256));
            // zero-size cube
            send_item(mk(vccp_pkg::REQ_QUERY, 0, 5120, 0, 0, 0, 0, 0, 0, 0, 0));
            // off to the side
            send_item(mk(vccp_pkg::REQ_QUERY, 0, 0, 20480, 0, 0, 0, 0, 0, 0, 256));
            // second view looking -x: the behind cube is now seen
            send_item(mk(vccp_pkg::REQ_LOAD, 1, 0, 0, 0, -16384, 0, 0, 56756, 32768, 0));
            send_item(mk(vccp_pkg::REQ_QUERY, 0, -10240, 0, 0, 0, 0, 0, 0, 0, 256));
        end
    endtask

    task automatic test_extremes;
        begin
            send_item(mk(REQ_NONE, 3, -1, -1, -1, -1, -1, -1, 131071, 131071, 32'hFFFF_FFFF));
            send_item(mk(vccp_pkg::REQ_LOAD, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         -32768, 32767, -32768, 131071, 131071, 32'hFFFF_FFFF));
            send_item(mk(vccp_pkg::REQ_QUERY, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         0, 0, 0, 0, 0, 32'hFFFF_FFFF));
            send_item(mk(vccp_pkg::REQ_LOAD, 2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         16384, 16384, 16384, 65536, 0, 0));
            send_item(mk(vccp_pkg::REQ_QUERY, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         0, 0, 0, 0, 0, 32'h0000_0001));
            send_item(mk(vccp_pkg::REQ_LOAD, 3, 0, 0, 0, 0, 0, 16384, 0, 65536, 0));
            send_item(mk(vccp_pkg::REQ_QUERY, 0, 100, -100, 3000, 0, 0, 0, 0, 0,
                         32'hFFFF_FFFF));
            send_item(mk(vccp_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            send_item(mk(vccp_pkg::REQ_QUERY, 0, 100, 100, 100, 0, 0, 0, 0, 0, 512));
            // the single loaded view sees the cube as out of view
            send_item(mk(vccp_pkg::REQ_LOAD, 0, 0, 0, 0, 0, 16384, 0, 65536, 0, 0));
            send_item(mk(vccp_pkg::REQ_QUERY, 0, 0, -20480, 0, 0, 0, 0, 0, 0, 256));
        end
    endtask

    function automatic int small_coord;
        return int'($urandom_range(0, 40000)) - 20000;
    endfunction

    task automatic test_random(input int count);
        vccp_pkg::req_t q;
        int   pick;
        int   ang;
        begin
            for (int n = 0; n < count; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    // noise: any field, any value
                    q = vccp_pkg::req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom,
                                                 $urandom, $urandom, $urandom}));
                end
                else if (pick < 14)
                    q = mk(vccp_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                else if (pick < 40)
                begin
                    q = mk(vccp_pkg::REQ_LOAD, $urandom_range(0, 3), small_coord(),
                           small_coord(), small_coord(), 0, 0, 0, 0, 0,
                           $urandom_range(0, 2048));
                    case ($urandom_range(0, 3))
                        0: q.dir_x = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
                        1: q.dir_y = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
                        2: q.dir_z = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
                        default:
                        begin
                            q.dir_x = 16'(int'($urandom_range(0, 32768)) - 16384);
                            q.dir_y = 16'(int'($urandom_range(0, 32768)) - 16384);
                            q.dir_z = 16'(int'($urandom_range(0, 32768)) - 16384);
                        end
                    endcase
                    ang = $urandom_range(0, 4);
                    case (ang)
                        0: begin q.cos_half = 17'd65536; q.sin_half = 17'd0;     end
                        1: begin q.cos_half = 17'd46341; q.sin_half = 17'd46341; end
                        2: begin q.cos_half = 17'd56756; q.sin_half = 17'd32768; end
                        3: begin q.cos_half = 17'd0;     q.sin_half = 17'd65536; end
                        default:
                        begin
                            q.cos_half = 17'($urandom_range(0, 65536));
                            q.sin_half = 17'($urandom_range(0, 65536));
                        end
                    endcase
                end
                else
                begin
                    q = mk(vccp_pkg::REQ_QUERY, $urandom_range(0, 3), small_coord(),
                           small_coord(), small_coord(), 0, 0, 0, 0, 0,
                           ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4096));
                end
                pace();
                send_item(q);
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        mismatches = 0;
        burst_left = 0;
        for (int i = 0; i < 4; i++)
            view_ok[i] = 1'b0;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        test_no_views();
        test_cone_cases();
        test_extremes();
        test_random(450);

        // drain: all outstanding queries, then a quiet tail for stray strobes
        idle(1);
        while (prio_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && prio_expected.size() == 0)
            $display("view_cone_cube_priority: match");
        else
            $display("view_cone_cube_priority: mismatch");
        $finish;
    end

endmodule
